// ===== sv/sic_pkg.sv =====
`timescale 1ns / 1ps

package sic_pkg;

    localparam int VALUE_W   = 10;
    localparam int GREATER_W = 16;
    localparam int TOTAL_W   = 32;
    localparam int EPOCH_W   = 8;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               start_new;
    } sic_in_t;

    typedef struct packed {
        logic [GREATER_W-1:0] greater_before;
        logic [TOTAL_W-1:0]   total_inversions;
        logic                 overflow;
    } sic_out_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_WALK,
        S_FINISH,
        S_RESULT
    } sic_state_t;

endpackage

// ===== sv/sic_tree_mem.sv =====
`timescale 1ns / 1ps

module sic_tree_mem #(
    parameter int ADDR_W = 11,
    parameter int DATA_W = 24
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic [ADDR_W-1:0] rd_addr_a,
    input  logic [ADDR_W-1:0] rd_addr_b,
    output logic [DATA_W-1:0] rd_data_a,
    output logic [DATA_W-1:0] rd_data_b
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

// ===== sv/sic_walker.sv =====
`timescale 1ns / 1ps

module sic_walker #(
    parameter int VALUE_BITS = 10,
    parameter int MAX_ITEMS  = 65535
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  sic_pkg::sic_in_t   in_word,
    output logic               in_stall,
    output logic               wr_en,
    output logic [VALUE_BITS:0] wr_addr,
    output logic [sic_pkg::EPOCH_W+$clog2(MAX_ITEMS+1)-1:0] wr_data,
    output logic [VALUE_BITS:0] rd_addr_a,
    output logic [VALUE_BITS:0] rd_addr_b,
    input  logic [sic_pkg::EPOCH_W+$clog2(MAX_ITEMS+1)-1:0] rd_data_a,
    input  logic [sic_pkg::EPOCH_W+$clog2(MAX_ITEMS+1)-1:0] rd_data_b,
    output logic               res_valid,
    output sic_pkg::sic_out_t  res_word,
    input  logic               res_ready
);

    localparam int NODE_W = VALUE_BITS + 1;
    localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
    localparam int LVL_W  = $clog2(VALUE_BITS + 1);
    localparam int EW     = sic_pkg::EPOCH_W;
    localparam int TW     = sic_pkg::TOTAL_W;

    sic_pkg::sic_state_t state_reg, state_next;
    logic [EW-1:0]     epoch_reg, epoch_next;
    logic [NODE_W-1:0] clr_addr_reg, clr_addr_next;
    logic              pend_reg, pend_next;
    logic              ins_reg, ins_next;
    logic [LVL_W-1:0]  lvl_reg, lvl_next;
    logic [NODE_W-1:0] node_reg, node_next;
    logic              p_valid_reg, p_valid_next;
    logic [NODE_W-1:0] p_node_reg, p_node_next;
    logic [CNT_W-1:0]  acc_reg, acc_next;
    logic [TW-1:0]     total_reg, total_next;
    logic [CNT_W-1:0]  elem_reg, elem_next;
    logic              ovf_reg, ovf_next;

    logic [CNT_W-1:0]  eff_a;
    logic [CNT_W-1:0]  eff_b;
    logic [TW:0]       sum;
    logic [TW-1:0]     acc_wide;
    logic [TW-1:0]     new_total;
    logic              new_ovf;
    logic [VALUE_BITS-1:0] in_value;

    assign in_value = VALUE_BITS'(in_word.value);

    // An entry written in an older sequence reads as zero.
    assign eff_a = (rd_data_a[EW+CNT_W-1:CNT_W] == epoch_reg) ? rd_data_a[CNT_W-1:0] : '0;
    assign eff_b = (rd_data_b[EW+CNT_W-1:CNT_W] == epoch_reg) ? rd_data_b[CNT_W-1:0] : '0;

    assign rd_addr_a = node_reg;
    assign rd_addr_b = {node_reg[NODE_W-1:1], ~node_reg[0]};

    assign wr_en   = (state_reg == sic_pkg::S_CLEAR) || (p_valid_reg && ins_reg);
    assign wr_addr = (state_reg == sic_pkg::S_CLEAR) ? clr_addr_reg : p_node_reg;
    assign wr_data = (state_reg == sic_pkg::S_CLEAR) ? '0 : {epoch_reg, eff_a + CNT_W'(1)};

    assign in_stall = (state_reg != sic_pkg::S_IDLE);

    assign acc_wide = TW'(acc_reg);
    assign sum      = {1'b0, total_reg} + {1'b0, acc_wide};

    always_comb
    begin
        if (ins_reg)
        begin
            new_total = sum[TW] ? '1 : sum[TW-1:0];
            new_ovf   = ovf_reg | sum[TW];
        end
        else
        begin
            new_total = total_reg;
            new_ovf   = 1'b1;
        end
    end

    always_comb
    begin
        res_word.greater_before   = (acc_wide > TW'(32'hFFFF)) ? 16'hFFFF
                                                               : acc_wide[15:0];
        res_word.total_inversions = new_total;
        res_word.overflow         = new_ovf;
    end

    always_comb
    begin
        state_next    = state_reg;
        epoch_next    = epoch_reg;
        clr_addr_next = clr_addr_reg;
        pend_next     = pend_reg;
        ins_next      = ins_reg;
        lvl_next      = lvl_reg;
        node_next     = node_reg;
        p_valid_next  = 1'b0;
        p_node_next   = node_reg;
        acc_next      = acc_reg;
        total_next    = total_reg;
        elem_next     = elem_reg;
        ovf_next      = ovf_reg;
        res_valid     = 1'b0;

        if (p_valid_reg && (p_node_reg != NODE_W'(1)) && !p_node_reg[0])
        begin
            acc_next = acc_reg + eff_b;
        end

        case (state_reg)
            sic_pkg::S_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + NODE_W'(1);
                if (clr_addr_reg == '1)
                begin
                    state_next = pend_reg ? sic_pkg::S_WALK : sic_pkg::S_IDLE;
                    pend_next  = 1'b0;
                end
            end
            sic_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    node_next = {1'b1, in_value};
                    lvl_next  = '0;
                    acc_next  = '0;
                    if (in_word.start_new)
                    begin
                        total_next = '0;
                        elem_next  = '0;
                        ovf_next   = 1'b0;
                        ins_next   = 1'b1;
                        if (epoch_reg == '1)
                        begin
                            epoch_next    = '0;
                            clr_addr_next = '0;
                            pend_next     = 1'b1;
                            state_next    = sic_pkg::S_CLEAR;
                        end
                        else
                        begin
                            epoch_next = epoch_reg + EW'(1);
                            state_next = sic_pkg::S_WALK;
                        end
                    end
                    else
                    begin
                        ins_next   = (elem_reg < CNT_W'(MAX_ITEMS));
                        state_next = sic_pkg::S_WALK;
                    end
                end
            end
            sic_pkg::S_WALK:
            begin
                p_valid_next = 1'b1;
                node_next    = node_reg >> 1;
                lvl_next     = lvl_reg + LVL_W'(1);
                if (lvl_reg == LVL_W'(VALUE_BITS))
                begin
                    state_next = sic_pkg::S_FINISH;
                end
            end
            sic_pkg::S_FINISH:
            begin
                state_next = sic_pkg::S_RESULT;
            end
            sic_pkg::S_RESULT:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    total_next = new_total;
                    ovf_next   = new_ovf;
                    if (ins_reg)
                    begin
                        elem_next = elem_reg + CNT_W'(1);
                    end
                    state_next = sic_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = sic_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= sic_pkg::S_CLEAR;
            epoch_reg    <= '0;
            clr_addr_reg <= '0;
            pend_reg     <= 1'b0;
            ins_reg      <= 1'b0;
            lvl_reg      <= '0;
            p_valid_reg  <= 1'b0;
            acc_reg      <= '0;
            total_reg    <= '0;
            elem_reg     <= '0;
            ovf_reg      <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            epoch_reg    <= epoch_next;
            clr_addr_reg <= clr_addr_next;
            pend_reg     <= pend_next;
            ins_reg      <= ins_next;
            lvl_reg      <= lvl_next;
            p_valid_reg  <= p_valid_next;
            acc_reg      <= acc_next;
            total_reg    <= total_next;
            elem_reg     <= elem_next;
            ovf_reg      <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        node_reg   <= node_next;
        p_node_reg <= p_node_next;
    end

    a_greater_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sic_pkg::S_RESULT) |-> (acc_reg <= elem_reg))
        else $error("greater count exceeds elements in the tree");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sic_pkg::S_IDLE) |-> !wr_en)
        else $error("tree write while idle");

    a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (ovf_reg && !(state_reg == sic_pkg::S_IDLE && in_valid && in_word.start_new))
        |=> ovf_reg)
        else $error("overflow flag cleared without a new sequence");

    a_total_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        !(state_reg == sic_pkg::S_IDLE && in_valid && in_word.start_new)
        |=> (total_reg >= $past(total_reg)))
        else $error("inversion total decreased within a sequence");

endmodule

// ===== sv/sic_out_slot.sv =====
`timescale 1ns / 1ps

module sic_out_slot (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    input  sic_pkg::sic_out_t push_word,
    output logic              push_ready,
    output logic              valid,
    output sic_pkg::sic_out_t word,
    input  logic              stall
);

    logic              valid_reg, valid_next;
    sic_pkg::sic_out_t word_reg, word_next;

    assign push_ready = !valid_reg || !stall;
    assign valid      = valid_reg;
    assign word       = word_reg;

    always_comb
    begin
        valid_next = valid_reg;
        word_next  = word_reg;
        if (push_valid && push_ready)
        begin
            valid_next = 1'b1;
            word_next  = push_word;
        end
        else if (!stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

endmodule

// ===== sv/streaming_inversion_counter_unit.sv =====
`timescale 1ns / 1ps
// Streaming inversion counter. Each input word carries one sequence element and a
// start flag; each element yields exactly one result word with the count of earlier
// greater elements, the saturating running inversion total and a sticky overflow flag.
// The input channel is item_valid/item_stall/item and the result channel is
// result_valid/result_stall/result; a word moves when valid is high and stall is low.
// Element counts live in a frequency sum tree held in one RAM of 2^(VALUE_BITS+1)
// words, read at two addresses and written at one per cycle. One walk from leaf to
// root answers the query and applies the increment; item_stall stays high from one
// acceptance until the walker has handed its result on, so elements go one at a time.
// Its result passes the WALK, FINISH and RESULT states, then the output register.
// After reset the block sweeps all 2^(VALUE_BITS+1) words of the RAM, one word a cycle,
// and holds item_stall high meanwhile. A start flag begins a new tree generation at no
// cost, except on every 256th start, which triggers the same sweep first.
// A stalled result waits in an output register while the next element is processed;
// the walker then holds its finished result until that register frees.
module streaming_inversion_counter_unit #(
    parameter int VALUE_BITS = 10,
    parameter int MAX_ITEMS  = 65535
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  sic_pkg::sic_in_t  item,
    output logic              result_valid,
    input  logic              result_stall,
    output sic_pkg::sic_out_t result
);

    localparam int NODE_W = VALUE_BITS + 1;
    localparam int WORD_W = sic_pkg::EPOCH_W + $clog2(MAX_ITEMS + 1);

    logic              wr_en;
    logic [NODE_W-1:0] wr_addr;
    logic [WORD_W-1:0] wr_data;
    logic [NODE_W-1:0] rd_addr_a;
    logic [NODE_W-1:0] rd_addr_b;
    logic [WORD_W-1:0] rd_data_a;
    logic [WORD_W-1:0] rd_data_b;
    logic              res_valid;
    logic              res_ready;
    sic_pkg::sic_out_t res_word;

    sic_tree_mem #(
        .ADDR_W (NODE_W),
        .DATA_W (WORD_W)
    ) u_mem (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    sic_walker #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_ITEMS  (MAX_ITEMS)
    ) u_walker (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item_valid),
        .in_word   (item),
        .in_stall  (item_stall),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b),
        .res_valid (res_valid),
        .res_word  (res_word),
        .res_ready (res_ready)
    );

    sic_out_slot u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (res_valid),
        .push_word  (res_word),
        .push_ready (res_ready),
        .valid      (result_valid),
        .word       (result),
        .stall      (result_stall)
    );

endmodule

// ===== dv/tb_streaming_inversion_counter_unit.sv =====
`timescale 1ns / 1ps

module tb_streaming_inversion_counter_unit;

    localparam int LEAVES       = 1 << sic_pkg::VALUE_W;
    localparam int ITEM_LIMIT   = 65535;
    localparam int LONG_SEQ     = 96;
    localparam int BURST_WORDS  = 300;
    localparam int SEQ_WORDS    = 220;
    localparam int HOLDOFF_AT   = 150;
    localparam int HOLDOFF_LEN  = 300;
    localparam int QUIET_FROM   = 380;
    localparam int QUIET_TO     = 460;
    localparam int TAIL_CYCLES  = 60;
    localparam int CYCLE_LIMIT  = 400000;
    localparam longint unsigned TOTAL_MAX = 64'hFFFF_FFFF;
    localparam int GREATER_MAX  = 16'hFFFF;

    typedef logic [sic_pkg::VALUE_W-1:0] value_t;

    typedef struct {
        value_t            value;
        logic              start_new;
        bit                pinned;
        sic_pkg::sic_out_t want;
    } stim_row_t;

    localparam int DIRECTED_ROWS = 25;

    // Pinned rows carry results that follow directly from the sequence so far.
    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        '{10'd700,  1'b0, 1'b1, '{16'd0, 32'd0, 1'b0}},
        '{10'd1023, 1'b0, 1'b1, '{16'd0, 32'd0, 1'b0}},
        '{10'd0,    1'b0, 1'b1, '{16'd2, 32'd2, 1'b0}},
        '{10'd1023, 1'b0, 1'b1, '{16'd0, 32'd2, 1'b0}},
        '{10'd0,    1'b0, 1'b1, '{16'd3, 32'd5, 1'b0}},
        '{10'd0,    1'b1, 1'b1, '{16'd0, 32'd0, 1'b0}},
        '{10'd1023, 1'b0, 1'b1, '{16'd0, 32'd0, 1'b0}},
        '{10'd1023, 1'b0, 1'b1, '{16'd0, 32'd0, 1'b0}},
        '{10'd1022, 1'b0, 1'b1, '{16'd2, 32'd2, 1'b0}},
        '{10'd1,    1'b0, 1'b0, '{16'd0, 32'd0, 1'b0}},
        '{10'h155,  1'b0, 1'b0, '{16'd0, 32'd0, 1'b0}},
        '{10'h2AA,  1'b0, 1'b0, '{16'd0, 32'd0, 1'b0}},
        '{10'd512,  1'b0, 1'b0, '{16'd0, 32'd0, 1'b0}},
        '{10'd511,  1'b0, 1'b0, '{16'd0, 32'd0, 1'b0}},
        '{10'd0,    1'b1, 1'b1, '{16'd0, 32'd0, 1'b0}},
        '{10'd0,    1'b0, 1'b1, '{16'd0, 32'd0, 1'b0}},
        '{10'd1,    1'b1, 1'b1, '{16'd0, 32'd0, 1'b0}},
        '{10'd1000, 1'b0, 1'b0, '{16'd0, 32'd0, 1'b0}},
        '{10'd900,  1'b0, 1'b0, '{16'd0, 32'd0, 1'b0}},
        '{10'd800,  1'b0, 1'b0, '{16'd0, 32'd0, 1'b0}},
        '{10'd600,  1'b0, 1'b0, '{16'd0, 32'd0, 1'b0}},
        '{10'd400,  1'b0, 1'b0, '{16'd0, 32'd0, 1'b0}},
        '{10'd200,  1'b0, 1'b0, '{16'd0, 32'd0, 1'b0}},
        '{10'd100,  1'b0, 1'b0, '{16'd0, 32'd0, 1'b0}},
        '{10'd0,    1'b0, 1'b0, '{16'd0, 32'd0, 1'b0}}
    };

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              item_valid = 1'b0;
    logic              item_stall;
    sic_pkg::sic_in_t  item = '0;
    logic              result_valid;
    logic              result_stall = 1'b0;
    sic_pkg::sic_out_t result;

    int unsigned freq_tree [2*LEAVES];
    int unsigned run_total;
    int unsigned seq_len;
    bit          seq_flagged;

    sic_pkg::sic_out_t expected_counts [$];
    bit                in_took;
    bit                pinned_row;
    sic_pkg::sic_out_t pinned_result;
    int                items_sent;
    int                results_seen;
    int                mismatches;
    int                cycle_count;
    bit                holdoff_done;

    streaming_inversion_counter_unit #(
        .VALUE_BITS (sic_pkg::VALUE_W),
        .MAX_ITEMS  (ITEM_LIMIT)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always #2 clk = ~clk;

    function automatic void clear_counts();
        foreach (freq_tree[i])
        begin
            freq_tree[i] = 0;
        end
        run_total   = 0;
        seq_len     = 0;
        seq_flagged = 1'b0;
    endfunction

    function automatic void note_expected(sic_pkg::sic_out_t r);
        expected_counts = {expected_counts, r};
    endfunction

    function automatic sic_pkg::sic_out_t predict_inversions(sic_pkg::sic_in_t w);
        int unsigned       node;
        int unsigned       greater;
        longint unsigned   sum;
        sic_pkg::sic_out_t r;
        if (w.start_new)
        begin
            clear_counts();
        end
        greater = 0;
        node = LEAVES + w.value;
        while (node > 1)
        begin
            if (node[0] == 1'b0)
            begin
                greater += freq_tree[node + 1];
            end
            node >>= 1;
        end
        if (seq_len >= ITEM_LIMIT)
        begin
            seq_flagged = 1'b1;
        end
        else
        begin
            sum = longint'(run_total) + longint'(greater);
            if (sum > TOTAL_MAX)
            begin
                sum = TOTAL_MAX;
                seq_flagged = 1'b1;
            end
            run_total = sum[31:0];
            node = LEAVES + w.value;
            while (node != 0)
            begin
                freq_tree[node] += 1;
                node >>= 1;
            end
            seq_len += 1;
        end
        r.greater_before   = (greater > GREATER_MAX) ? GREATER_MAX[15:0] : greater[15:0];
        r.total_inversions = run_total;
        r.overflow         = seq_flagged;
        return r;
    endfunction

    function automatic value_t pick_value(int mode, int k);
        case (mode)
            0: return value_t'($urandom_range(LEAVES - 1));
            1: return value_t'($urandom_range(7));
            2:
            begin
                case ($urandom_range(3))
                    0: return '0;
                    1: return '1;
                    2: return value_t'(LEAVES / 2);
                    default: return value_t'(LEAVES / 2 - 1);
                endcase
            end
            default: return value_t'(LEAVES - 1 - ((k * 9) % LEAVES));
        endcase
    endfunction

    task automatic check_field(string label, longint unsigned want, longint unsigned got);
        if (want != got)
        begin
            mismatches++;
            $display("%0t %s expected %0d actual %0d", $time, label, want, got);
        end
    endtask

    task automatic send_word(sic_pkg::sic_in_t w, bit pin, sic_pkg::sic_out_t pin_res);
        pinned_row    = pin;
        pinned_result = pin_res;
        item       <= w;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_took);
        items_sent++;
        if (!(items_sent >= QUIET_FROM && items_sent < QUIET_TO) && $urandom_range(99) < 18)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    // Handshakes are sampled at the falling edge, where inputs and outputs are stable.
    always @(negedge clk)
    begin
        sic_pkg::sic_out_t predicted;
        sic_pkg::sic_out_t want;
        in_took = rst_n && item_valid && !item_stall;
        if (in_took)
        begin
            predicted = predict_inversions(item);
            note_expected(pinned_row ? pinned_result : predicted);
        end
        if (rst_n && result_valid && !result_stall)
        begin
            results_seen++;
            if (expected_counts.size() == 0)
            begin
                mismatches++;
                $display("%0t unexpected result expected none actual %0d/%0d/%0d", $time,
                         result.greater_before, result.total_inversions, result.overflow);
            end
            else
            begin
                want = expected_counts.pop_front();
                check_field("greater_before", want.greater_before, result.greater_before);
                check_field("total_inversions", want.total_inversions,
                            result.total_inversions);
                check_field("overflow", want.overflow, result.overflow);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("%0t timeout with %0d words outstanding", $time, expected_counts.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // The receiver stalls at random and holds off once for a long stretch.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (!holdoff_done && results_seen >= HOLDOFF_AT)
            begin
                holdoff_done = 1'b1;
                result_stall <= 1'b1;
                repeat (HOLDOFF_LEN) @(posedge clk);
            end
            if (results_seen >= QUIET_FROM && results_seen < QUIET_TO)
            begin
                result_stall <= 1'b0;
            end
            else
            begin
                result_stall <= ($urandom_range(99) < 18);
            end
        end
    end

    initial
    begin
        sic_pkg::sic_in_t w;
        int               sent;
        int               len;
        int               mode;
        int               r;
        bit               first;
        clear_counts();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int n = 0; n < DIRECTED_ROWS; n++)
        begin
            w.value     = directed_rows[n].value;
            w.start_new = directed_rows[n].start_new;
            send_word(w, directed_rows[n].pinned, directed_rows[n].want);
        end

        // Mostly fresh sequences, so the start counter wraps and forces a clearing sweep.
        for (int n = 0; n < BURST_WORDS; n++)
        begin
            w.value     = pick_value($urandom_range(3), n);
            w.start_new = ($urandom_range(9) != 0);
            send_word(w, 1'b0, '0);
        end

        item_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_counts.size() != 0);

        sent  = 0;
        first = 1'b1;
        while (sent < SEQ_WORDS)
        begin
            r = $urandom_range(9);
            if (first)
                len = LONG_SEQ + 12;
            else if (r < 3)
                len = $urandom_range(1, 3);
            else if (r < 8)
                len = $urandom_range(4, 40);
            else
                len = $urandom_range(LONG_SEQ - 4, LONG_SEQ + 16);
            mode = $urandom_range(3);
            for (int k = 0; k < len; k++)
            begin
                w.value     = pick_value(mode, k);
                w.start_new = (k == 0) || ($urandom_range(49) == 0);
                send_word(w, 1'b0, '0);
            end
            sent += len;
            first = 1'b0;
        end

        item_valid <= 1'b0;
        while (expected_counts.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== files.f =====
sv/sic_pkg.sv
sv/sic_tree_mem.sv
sv/sic_walker.sv
sv/sic_out_slot.sv
sv/streaming_inversion_counter_unit.sv
dv/tb_streaming_inversion_counter_unit.sv
